// File: src/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types, constants and character helpers for the fuzzy subsequence
// scorer: queue word layout, character classes and score constants.
// ----------------------------------------------------------------------------
package fss_pkg;

   // Default sizes handed to the top-level parameters
   localparam int          MAX_PATTERN_DEF  = 64;
   localparam int unsigned TARGET_LIMIT_DEF = 65535;

   // Port field widths
   localparam int CHAR_W     = 8;
   localparam int POS_OUT_W  = 16;
   localparam int SCORE_W    = 18;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;

   // Result word layout, lowest bit first
   localparam int RSP_HIT_BIT      = 0;
   localparam int RSP_POS_LSB      = 1;
   localparam int RSP_MATCHED_BIT  = RSP_POS_LSB + POS_OUT_W;
   localparam int RSP_SCORE_LSB    = RSP_MATCHED_BIT + 1;
   localparam int RSP_SCORE_MSB    = RSP_SCORE_LSB + SCORE_W - 1;
   localparam int RSP_TOO_LONG_BIT = RSP_SCORE_MSB + 1;
   localparam int RSP_PAD_W        = RSP_DATA_W - RSP_TOO_LONG_BIT - 1;

   // Queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Score constants
   localparam logic signed [SCORE_W-1:0] SCORE_MAX = 18'sh1FFFF;
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = 18'sh20000;
   localparam logic [5:0] MATCH_BASE     = 6'd16;
   localparam logic [4:0] BONUS_BOUNDARY = 5'd8;
   localparam logic [4:0] BONUS_CHANGE   = 5'd7;
   localparam logic [4:0] BONUS_CONSEC   = 5'd4;
   localparam int         GAP_EXTRA      = 2;

   typedef enum logic {
      ACT_PATTERN = 1'b0,
      ACT_TARGET  = 1'b1
   } act_type;

   typedef enum logic [2:0] {
      CLS_LOWER = 3'd0,
      CLS_UPPER = 3'd1,
      CLS_DIGIT = 3'd2,
      CLS_DELIM = 3'd3,
      CLS_OTHER = 3'd4
   } cls_type;

   // One classified word as it waits in the queue
   typedef struct packed {
      act_type           action;
      logic [CHAR_W-1:0] code;   // folded to lower case
      cls_type           cls;    // class of the raw byte
      logic              last;
   } q_item_type;

   // Fold A-Z to a-z, leave everything else
   function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   // Sort a raw byte into lower, upper, digit, delimiter or other
   function automatic cls_type char_class(input logic [CHAR_W-1:0] c);
      cls_type r;
      r = CLS_OTHER;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = CLS_LOWER;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         r = CLS_UPPER;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = CLS_DIGIT;
      end else if (c inside {8'h5F, 8'h2D, 8'h2E, 8'h2F, 8'h3A, 8'h3B, 8'h2C}) begin
         r = CLS_DELIM;
      end
      return r;
   endfunction

endpackage

// File: src/fss_ram.sv
// ----------------------------------------------------------------------------
// fss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/fss_front.sv
// ----------------------------------------------------------------------------
// fss_front
// Accepts request words, folds and classifies the byte, and holds the
// classified words in a short queue for the back end.
// ----------------------------------------------------------------------------
module fss_front
   import fss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] char_code
   input  logic                  req_tuser,   // [0] action
   input  logic                  req_tlast,
   output logic                  q_valid,
   output q_item_type            q_item,
   input  logic                  q_pop
);

   q_item_type          entries_ff [QUEUE_DEPTH];
   q_item_type          entry_in;
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   // Classify the incoming byte
   always_comb begin
      entry_in.action = act_type'(req_tuser);
      entry_in.code   = fold_char(req_tdata[CHAR_W-1:0]);
      entry_in.cls    = char_class(req_tdata[CHAR_W-1:0]);
      entry_in.last   = req_tlast;
   end

   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign pop        = q_pop && q_valid;
   assign q_item     = entries_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified word
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

// File: src/fss_back.sv
// ----------------------------------------------------------------------------
// fss_back
// Executes queued words: writes pattern bytes into the pattern RAM, matches
// target bytes against the next pattern byte, keeps the running score and
// drives the registered response word.
// ----------------------------------------------------------------------------
module fss_back
   import fss_pkg::*;
#(
   parameter int          MAX_PATTERN  = MAX_PATTERN_DEF,
   parameter int unsigned TARGET_LIMIT = TARGET_LIMIT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  q_item_type            q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int AW     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LW     = $clog2(MAX_PATTERN + 1);
   localparam int POS_W  = $clog2(TARGET_LIMIT + 2);
   localparam int POSX_W = (POS_W > POS_OUT_W) ? POS_W : POS_OUT_W;
   localparam int DW     = ((POS_W + 1 > SCORE_W) ? POS_W + 1 : SCORE_W) + 1;
   localparam logic [LW-1:0]    MAX_LEN   = LW'(MAX_PATTERN);
   localparam logic [POS_W-1:0] LIMIT_POS = POS_W'(TARGET_LIMIT);

   // Pattern and target state
   logic [LW-1:0]              len_ff, len_in;
   logic                       closed_ff, closed_in;
   logic [LW-1:0]              mc_ff, mc_in;
   logic [POS_W-1:0]           tpos_ff, tpos_in;
   logic [POS_W-1:0]           gap_ff, gap_in;
   cls_type                    prev_cls_ff, prev_cls_in;
   logic signed [SCORE_W-1:0]  score_ff, score_in;
   logic                       ovf_ff, ovf_in;

   // Response register
   logic                       out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0]      out_data_ff, out_data_in;
   logic                       out_last_ff, out_last_in;

   // Read-during-write bypass for the pattern RAM
   logic                       byp_ff, byp_in;
   logic [CHAR_W-1:0]          byp_data_ff;

   logic                       go, is_pat, is_tgt;
   logic [LW-1:0]              len_eff;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr, rd_addr;
   logic [CHAR_W-1:0]          ram_q, pat_char;

   logic                       in_range, hit, first, consec, ok, fin;
   logic [4:0]                 bonus_raw, bonus_c, bonus_f;
   logic [5:0]                 add_val;
   logic signed [SCORE_W:0]    sum1;
   logic signed [SCORE_W-1:0]  sat1, sat2;
   logic [POS_W:0]             pen;
   logic signed [DW-1:0]       diff, min_ext;
   logic [LW-1:0]              mc_tgt;
   logic signed [SCORE_W-1:0]  score_tgt;
   logic                       ovf_tgt;
   logic [POS_W-1:0]           pos_sel;
   logic [POSX_W-1:0]          pos_ext;
   logic [RSP_DATA_W-1:0]      rsp_word;

   // Advance when a pattern word arrives or the response slot is free
   assign go     = q_valid && (q_item.action == ACT_PATTERN || !out_valid_ff || rsp_tready);
   assign q_pop  = go;
   assign is_pat = go && (q_item.action == ACT_PATTERN);
   assign is_tgt = go && (q_item.action == ACT_TARGET);

   // Pattern write: a closed pattern restarts at zero
   assign len_eff = closed_ff ? '0 : len_ff;
   assign wr_en   = is_pat && (len_eff < MAX_LEN);
   assign wr_addr = len_eff[AW-1:0];
   assign rd_addr = mc_in[AW-1:0];
   assign byp_in  = wr_en && (wr_addr == rd_addr);

   fss_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (MAX_PATTERN)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (q_item.code),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign pat_char = byp_ff ? byp_data_ff : ram_q;

   // Compare and bonus for a target byte
   always_comb begin
      in_range = (tpos_ff <= LIMIT_POS);
      hit      = in_range && (mc_ff < len_ff) && (q_item.code == pat_char);
      first    = (mc_ff == '0);
      consec   = !first && (gap_ff == '0);

      bonus_raw = 5'd0;
      if (tpos_ff == '0 || prev_cls_ff == CLS_DELIM) begin
         bonus_raw = BONUS_BOUNDARY;
      end else if (prev_cls_ff == CLS_LOWER && q_item.cls == CLS_UPPER) begin
         bonus_raw = BONUS_CHANGE;
      end else if ((prev_cls_ff == CLS_LOWER || prev_cls_ff == CLS_UPPER) &&
                   q_item.cls == CLS_DIGIT) begin
         bonus_raw = BONUS_CHANGE;
      end else if (prev_cls_ff == CLS_DIGIT &&
                   (q_item.cls == CLS_LOWER || q_item.cls == CLS_UPPER)) begin
         bonus_raw = BONUS_CHANGE;
      end
      bonus_c = (consec && bonus_raw < BONUS_CONSEC) ? BONUS_CONSEC : bonus_raw;
      bonus_f = first ? {bonus_c[3:0], 1'b0} : bonus_c;
      add_val = MATCH_BASE + {1'b0, bonus_f};
   end

   // Saturating score update: add match credit, then charge the gap
   always_comb begin
      sum1 = $signed({score_ff[SCORE_W-1], score_ff}) +
             $signed({{(SCORE_W - 5){1'b0}}, add_val});
      sat1 = (sum1[SCORE_W] != sum1[SCORE_W-1]) ? SCORE_MAX : sum1[SCORE_W-1:0];

      pen     = {1'b0, gap_ff} + (POS_W + 1)'(GAP_EXTRA);
      diff    = $signed({{(DW - SCORE_W){sat1[SCORE_W-1]}}, sat1}) -
                $signed({{(DW - POS_W - 1){1'b0}}, pen});
      min_ext = $signed({{(DW - SCORE_W){1'b1}}, SCORE_MIN});
      if (gap_ff == '0) begin
         sat2 = sat1;
      end else if (diff < min_ext) begin
         sat2 = SCORE_MIN;
      end else begin
         sat2 = diff[SCORE_W-1:0];
      end
   end

   // Outcome of this target byte
   always_comb begin
      mc_tgt    = hit ? mc_ff + 1'b1 : mc_ff;
      score_tgt = hit ? sat2 : score_ff;
      ovf_tgt   = ovf_ff || !in_range;
      ok        = (mc_tgt >= len_ff);
      fin       = q_item.last && ok;
      pos_sel   = in_range ? tpos_ff : LIMIT_POS;
      pos_ext   = POSX_W'(pos_sel);
      rsp_word  = {{RSP_PAD_W{1'b0}},
                   q_item.last && ovf_tgt,
                   fin ? score_tgt : '0,
                   fin,
                   pos_ext[POS_OUT_W-1:0],
                   hit};
   end

   // Next state
   always_comb begin
      len_in      = len_ff;
      closed_in   = closed_ff;
      mc_in       = mc_ff;
      tpos_in     = tpos_ff;
      gap_in      = gap_ff;
      prev_cls_in = prev_cls_ff;
      score_in    = score_ff;
      ovf_in      = ovf_ff;

      if (is_pat) begin
         len_in    = wr_en ? len_eff + 1'b1 : len_eff;
         closed_in = q_item.last;
         if (closed_ff) begin
            mc_in       = '0;
            tpos_in     = '0;
            gap_in      = '0;
            prev_cls_in = CLS_LOWER;
            score_in    = '0;
            ovf_in      = 1'b0;
         end
      end else if (is_tgt) begin
         closed_in = 1'b1;
         if (q_item.last) begin
            mc_in       = '0;
            tpos_in     = '0;
            gap_in      = '0;
            prev_cls_in = CLS_LOWER;
            score_in    = '0;
            ovf_in      = 1'b0;
         end else begin
            mc_in       = mc_tgt;
            tpos_in     = in_range ? tpos_ff + 1'b1 : tpos_ff;
            gap_in      = !in_range ? gap_ff : (hit ? '0 : gap_ff + 1'b1);
            prev_cls_in = q_item.cls;
            score_in    = score_tgt;
            ovf_in      = ovf_tgt;
         end
      end
   end

   // Response slot: load on a target word, drop once taken
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (is_tgt) begin
         out_valid_in = 1'b1;
         out_data_in  = rsp_word;
         out_last_in  = q_item.last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         closed_ff    <= 1'b1;
         mc_ff        <= '0;
         tpos_ff      <= '0;
         gap_ff       <= '0;
         prev_cls_ff  <= CLS_LOWER;
         score_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         byp_ff       <= 1'b0;
      end else begin
         len_ff       <= len_in;
         closed_ff    <= closed_in;
         mc_ff        <= mc_in;
         tpos_ff      <= tpos_in;
         gap_ff       <= gap_in;
         prev_cls_ff  <= prev_cls_in;
         score_ff     <= score_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
         byp_ff       <= byp_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      byp_data_ff <= q_item.code;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// File: src/fuzzy_subsequence_scorer.sv
// A target word waits in the front queue and its response in the response register.
// Throughput: one word per cycle unless a full response slot is not taken; the
// per-byte compare and saturating score update in the back end are combinational,
// fed by a two-word queue. Pattern words produce no response and also retire at
// one per cycle.
// Reset (synchronous, active high) empties the queue and the response slot and
// leaves an empty, closed pattern; the pattern RAM is not cleared.
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer
// Greedy case-insensitive fuzzy subsequence matcher with position bonuses
// and gap penalties, one target byte per cycle while the response slot is free or taken.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer
   import fss_pkg::*;
#(
   parameter int          MAX_PATTERN  = MAX_PATTERN_DEF,
   parameter int unsigned TARGET_LIMIT = TARGET_LIMIT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] char_code
   input  logic                  req_tuser,  // [0] action
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [0] hit, [16:1] position, [17] matched,
                                             // [35:18] score, [36] too_long, [39:37] zero
   output logic                  rsp_tlast
);

   logic       q_valid, q_pop;
   q_item_type q_item;

   fss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   fss_back #(
      .MAX_PATTERN  (MAX_PATTERN),
      .TARGET_LIMIT (TARGET_LIMIT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Final fields stay zero on words that do not end a target
   a_final_only_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[RSP_TOO_LONG_BIT:RSP_MATCHED_BIT] == '0)
      else $error("final fields set on a non-final word");

   // A nonzero score only comes with a full match
   a_score_needs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_SCORE_MSB:RSP_SCORE_LSB] != '0 |->
      rsp_tdata[RSP_MATCHED_BIT])
      else $error("nonzero score without a match");

   // Once positions saturate no later byte can match
   a_no_hit_when_long: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && rsp_tdata[RSP_TOO_LONG_BIT] |-> !rsp_tdata[RSP_HIT_BIT])
      else $error("hit on a saturated position");

endmodule
